### sv/sga_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted group aggregate block.
// No dependencies; imported by every module of the block.
package sga_pkg;

  typedef enum logic [2:0] {
    AGG_MAX   = 3'd0,
    AGG_MIN   = 3'd1,
    AGG_SUM   = 3'd2,
    AGG_AVG   = 3'd3,
    AGG_COUNT = 3'd4
  } agg_func_e;

  typedef enum logic [2:0] {
    CMP_LT = 3'd0,
    CMP_GT = 3'd1,
    CMP_LE = 3'd2,
    CMP_GE = 3'd3,
    CMP_EQ = 3'd4,
    CMP_NE = 3'd5
  } cmp_op_e;

  typedef enum logic [1:0] {
    CFG_HAVING_FUNC = 2'd0,
    CFG_RESULT_FUNC = 2'd1,
    CFG_COMPARE_OP  = 2'd2,
    CFG_THRESHOLD   = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned FieldWidth   = 32;
  localparam int unsigned TallyWidth   = 32;

  typedef enum logic {
    COL_HAVING = 1'b0,
    COL_RESULT = 1'b1
  } col_sel_e;

  typedef enum logic {
    SLOT_FIRST  = 1'b0,
    SLOT_SECOND = 1'b1
  } slot_sel_e;

  typedef struct packed {
    logic      load_row;
    logic      start_div;
    col_sel_e  div_sel;
    logic      cap_having;
    logic      cap_result;
    logic      test;
    slot_sel_e slot_sel;
    logic      close;
    logic      add_row;
    logic      out_load;
    slot_sel_e out_sel;
    logic      out_last;
  } sga_cmd_t;

  typedef struct packed {
    logic key_differs;
    logic group_open;
    logic row_last;
    logic having_div;
    logic result_div;
    logic div_done;
    logic slot1_pass;
    logic slot2_pass;
    logic out_free;
  } sga_status_t;

endpackage

### sv/sorted_group_aggregate_having.sv
`timescale 1ns / 1ps
// Streaming GROUP BY with HAVING over key-sorted rows; one row in flight at a time.
// The next row is taken only after the current one is folded in and any group it closes
// is evaluated (two when a last row closes the open group and its own); each AVG
// evaluation waits for the divider, and a full output register holds the emit step until
// it drains.
// Reset is asynchronous and active low: no group open, empty accumulators, config zero.
module sorted_group_aggregate_having #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sga_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [sga_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [95:0]                      s_axis_tdata,  // group_key, having_value, result_value
  input  logic                             s_axis_tlast,  // last_row
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [63:0]                      m_axis_tdata,  // out_key, aggregate
  output logic                             m_axis_tlast   // last_of_run
);
  import sga_pkg::*;

  sga_cmd_t    dp_cmd;
  sga_status_t dp_st;

  sga_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (dp_st),
    .cmd_o      (dp_cmd)
  );

  sga_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .cmd_i      (dp_cmd),
    .status_o   (dp_st),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("row transfer while a row is still in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.start_div |=> !dp_st.div_done)
    else $error("divider reports done right after start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |-> dp_st.out_free)
    else $error("output register overwritten before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.add_row |=> dp_st.group_open)
    else $error("group not open after row accumulate");
`endif

endmodule

### sv/sga_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, signed dividend by unsigned divisor.
// Depends on sga_pkg.
module sga_div #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [VALUE_WIDTH-1:0] dividend_i,
  input  logic [sga_pkg::TallyWidth-1:0] divisor_i,
  output logic                          done_o,
  output logic signed [VALUE_WIDTH-1:0] quot_o
);
  import sga_pkg::*;

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH + 1);

  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [TallyWidth-1:0]  rem_q, rem_d;
  logic [TallyWidth-1:0]  div_q, div_d;
  logic [TallyWidth:0]    trial;
  logic                   fits;

  always_comb begin
    trial = {rem_q, quo_q[VALUE_WIDTH-1]};
    fits  = trial >= {1'b0, div_q};
    cnt_d  = cnt_q;
    done_d = done_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      neg_d  = dividend_i[VALUE_WIDTH-1];
      quo_d  = dividend_i[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - dividend_i) : dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CntWidth'(VALUE_WIDTH);
      done_d = 1'b0;
    end else if (cnt_q != '0) begin
      rem_d = fits ? TallyWidth'(trial - {1'b0, div_q}) : trial[TallyWidth-1:0];
      quo_d = {quo_q[VALUE_WIDTH-2:0], fits};
      cnt_d = cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? signed'(VALUE_WIDTH'(0) - quo_q) : signed'(quo_q);

endmodule

### sv/sga_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, row register, accumulators, close evaluation,
// result slots and output register. Depends on sga_pkg and sga_div.
module sga_datapath #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sga_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [sga_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic [95:0]                        s_tdata_i,
  input  logic                               s_tlast_i,
  input  sga_pkg::sga_cmd_t                  cmd_i,
  output sga_pkg::sga_status_t               status_o,
  input  logic                               m_tready_i,
  output logic                               m_tvalid_o,
  output logic [63:0]                        m_tdata_o,
  output logic                               m_tlast_o
);
  import sga_pkg::*;

  localparam logic signed [VALUE_WIDTH-1:0] VMax = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMin = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic [2:0]            having_func_q, result_func_q, compare_op_q;
  logic [FieldWidth-1:0] threshold_q;

  logic [FieldWidth-1:0]         row_key_q;
  logic signed [VALUE_WIDTH-1:0] row_hv_q, row_rv_q;
  logic                          row_last_q;

  logic                          open_q;
  logic [FieldWidth-1:0]         cur_key_q;
  logic signed [VALUE_WIDTH-1:0] hmin_q, hmax_q, hsum_q, rmin_q, rmax_q, rsum_q;
  logic [TallyWidth-1:0]         tally_q;

  logic signed [VALUE_WIDTH-1:0] hval_q, rval_q;
  logic [1:0]                    slot_pass_q;
  logic [FieldWidth-1:0]         slot_key_q [2];
  logic [FieldWidth-1:0]         slot_agg_q [2];

  logic                          m_valid_q;
  logic [63:0]                   m_data_q;
  logic                          m_last_q;

  logic signed [VALUE_WIDTH-1:0] count_val, threshold_v, quot;
  logic [63:0]                   tally_ext;
  logic                          having_div, result_div, div_done, out_free, pass;

  function automatic logic signed [VALUE_WIDTH-1:0] pick(
    input logic [2:0]                    func,
    input logic signed [VALUE_WIDTH-1:0] mn,
    input logic signed [VALUE_WIDTH-1:0] mx,
    input logic signed [VALUE_WIDTH-1:0] sm,
    input logic signed [VALUE_WIDTH-1:0] cnt
  );
    logic signed [VALUE_WIDTH-1:0] r;
    case (func)
      AGG_MAX:   r = mx;
      AGG_MIN:   r = mn;
      AGG_SUM:   r = sm;
      AGG_COUNT: r = cnt;
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic passes(
    input logic [2:0]                    op,
    input logic signed [VALUE_WIDTH-1:0] v,
    input logic signed [VALUE_WIDTH-1:0] t
  );
    logic r;
    case (op)
      CMP_LT:  r = v < t;
      CMP_GT:  r = v > t;
      CMP_LE:  r = v <= t;
      CMP_GE:  r = v >= t;
      CMP_EQ:  r = v == t;
      CMP_NE:  r = v != t;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  assign tally_ext   = {32'b0, tally_q};
  assign count_val   = signed'(tally_ext[VALUE_WIDTH-1:0]);
  assign threshold_v = VALUE_WIDTH'(signed'(threshold_q));
  assign having_div  = (having_func_q == AGG_AVG) && (tally_q != '0);
  assign result_div  = (result_func_q == AGG_AVG) && (tally_q != '0);
  assign out_free    = !m_valid_q || m_tready_i;
  assign pass        = passes(compare_op_q, hval_q, threshold_v);

  sga_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i ((cmd_i.div_sel == COL_HAVING) ? hsum_q : rsum_q),
    .divisor_i  (tally_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      having_func_q <= '0;
      result_func_q <= '0;
      compare_op_q  <= '0;
      threshold_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HAVING_FUNC: having_func_q <= cfg_data_i[2:0];
        CFG_RESULT_FUNC: result_func_q <= cfg_data_i[2:0];
        CFG_COMPARE_OP:  compare_op_q  <= cfg_data_i[2:0];
        CFG_THRESHOLD:   threshold_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      cur_key_q   <= '0;
      hmin_q      <= VMax;
      hmax_q      <= VMin;
      hsum_q      <= '0;
      rmin_q      <= VMax;
      rmax_q      <= VMin;
      rsum_q      <= '0;
      tally_q     <= '0;
      slot_pass_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.load_row) begin
        slot_pass_q <= '0;
      end
      if (cmd_i.test) begin
        slot_pass_q[cmd_i.slot_sel] <= pass;
      end
      if (cmd_i.close) begin
        open_q  <= 1'b0;
        hmin_q  <= VMax;
        hmax_q  <= VMin;
        hsum_q  <= '0;
        rmin_q  <= VMax;
        rmax_q  <= VMin;
        rsum_q  <= '0;
        tally_q <= '0;
      end else if (cmd_i.add_row) begin
        open_q    <= 1'b1;
        cur_key_q <= row_key_q;
        hmin_q    <= (row_hv_q < hmin_q) ? row_hv_q : hmin_q;
        hmax_q    <= (row_hv_q > hmax_q) ? row_hv_q : hmax_q;
        hsum_q    <= hsum_q + row_hv_q;
        rmin_q    <= (row_rv_q < rmin_q) ? row_rv_q : rmin_q;
        rmax_q    <= (row_rv_q > rmax_q) ? row_rv_q : rmax_q;
        rsum_q    <= rsum_q + row_rv_q;
        tally_q   <= tally_q + TallyWidth'(1);
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      row_key_q  <= s_tdata_i[31:0];
      row_hv_q   <= VALUE_WIDTH'(signed'(s_tdata_i[63:32]));
      row_rv_q   <= VALUE_WIDTH'(signed'(s_tdata_i[95:64]));
      row_last_q <= s_tlast_i;
    end
    if (cmd_i.cap_having) begin
      hval_q <= having_div ? quot : pick(having_func_q, hmin_q, hmax_q, hsum_q, count_val);
    end
    if (cmd_i.cap_result) begin
      rval_q <= result_div ? quot : pick(result_func_q, rmin_q, rmax_q, rsum_q, count_val);
    end
    if (cmd_i.test) begin
      slot_key_q[cmd_i.slot_sel] <= cur_key_q;
      slot_agg_q[cmd_i.slot_sel] <= FieldWidth'(rval_q);
    end
    if (cmd_i.out_load) begin
      m_data_q <= {slot_agg_q[cmd_i.out_sel], slot_key_q[cmd_i.out_sel]};
      m_last_q <= cmd_i.out_last;
    end
  end

  always_comb begin
    status_o.key_differs = row_key_q != cur_key_q;
    status_o.group_open  = open_q;
    status_o.row_last    = row_last_q;
    status_o.having_div  = having_div;
    status_o.result_div  = result_div;
    status_o.div_done    = div_done;
    status_o.slot1_pass  = slot_pass_q[SLOT_FIRST];
    status_o.slot2_pass  = slot_pass_q[SLOT_SECOND];
    status_o.out_free    = out_free;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;

endmodule

### sv/sga_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: row intake, group close sequencing and result hand-off.
// Depends on sga_pkg.
module sga_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  sga_pkg::sga_status_t status_i,
  output sga_pkg::sga_cmd_t    cmd_o
);
  import sga_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DECIDE = 10'b00_0000_0010,
    S_HAVE   = 10'b00_0000_0100,
    S_HDIV   = 10'b00_0000_1000,
    S_RES    = 10'b00_0001_0000,
    S_RDIV   = 10'b00_0010_0000,
    S_TEST   = 10'b00_0100_0000,
    S_ADD    = 10'b00_1000_0000,
    S_EMIT1  = 10'b01_0000_0000,
    S_EMIT2  = 10'b10_0000_0000
  } state_e;

  state_e    state_q, state_d;
  slot_sel_e phase_q, phase_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load_row = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status_i.group_open && status_i.key_differs) begin
          phase_d = SLOT_FIRST;
          state_d = S_HAVE;
        end else begin
          state_d = S_ADD;
        end
      end
      S_HAVE: begin
        if (status_i.having_div) begin
          cmd_o.start_div = 1'b1;
          cmd_o.div_sel   = COL_HAVING;
          state_d = S_HDIV;
        end else begin
          cmd_o.cap_having = 1'b1;
          state_d = S_RES;
        end
      end
      S_HDIV: begin
        if (status_i.div_done) begin
          cmd_o.cap_having = 1'b1;
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (status_i.result_div) begin
          cmd_o.start_div = 1'b1;
          cmd_o.div_sel   = COL_RESULT;
          state_d = S_RDIV;
        end else begin
          cmd_o.cap_result = 1'b1;
          state_d = S_TEST;
        end
      end
      S_RDIV: begin
        if (status_i.div_done) begin
          cmd_o.cap_result = 1'b1;
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        cmd_o.test     = 1'b1;
        cmd_o.slot_sel = phase_q;
        cmd_o.close    = 1'b1;
        state_d = (phase_q == SLOT_FIRST) ? S_ADD : S_EMIT1;
      end
      S_ADD: begin
        cmd_o.add_row = 1'b1;
        if (status_i.row_last) begin
          phase_d = SLOT_SECOND;
          state_d = S_HAVE;
        end else begin
          state_d = S_EMIT1;
        end
      end
      S_EMIT1: begin
        if (!status_i.slot1_pass) begin
          state_d = S_EMIT2;
        end else if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SLOT_FIRST;
          cmd_o.out_last = !status_i.slot2_pass;
          state_d = S_EMIT2;
        end
      end
      S_EMIT2: begin
        if (!status_i.slot2_pass) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SLOT_SECOND;
          cmd_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= SLOT_FIRST;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign s_tready_o = state_q == S_IDLE;

endmodule

### tb/sv/sorted_group_aggregate_having_check.sv
`timescale 1ns / 1ps
// Checker for sorted_group_aggregate_having: watches the config port and both streams,
// predicts the groups that pass the HAVING test and compares every output transfer.
// Depends on sga_pkg for the aggregate, compare and register codes.
module sorted_group_aggregate_having_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sga_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [sga_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [95:0]                      s_tdata_i,  // group_key, having_value, result_value
  input  logic                             s_tlast_i,  // last_row
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [63:0]                      m_tdata_i,  // out_key, aggregate
  input  logic                             m_tlast_i,  // last_of_run
  output int                               fail_count_o,
  output int                               pending_o
);
  import sga_pkg::*;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] agg;
    logic        last;
  } group_row_t;

  group_row_t passed_q[$];
  group_row_t step_rows[$];

  logic [2:0]         hav_fn, res_fn, cmp_sel;
  logic signed [31:0] thr;

  logic               grp_open;
  logic signed [31:0] grp_key;
  logic signed [31:0] hav_min, hav_max, hav_sum;
  logic signed [31:0] res_min, res_max, res_sum;
  logic [31:0]        tally;

  function automatic logic signed [31:0] aggregate_of(input logic [2:0] fn,
                                                      input logic signed [31:0] mn,
                                                      input logic signed [31:0] mx,
                                                      input logic signed [31:0] sum,
                                                      input logic [31:0] cnt);
    logic [32:0] mag;
    logic [32:0] quo;
    case (fn)
      AGG_MAX:   return mx;
      AGG_MIN:   return mn;
      AGG_SUM:   return sum;
      AGG_AVG: begin
        if (cnt == 32'd0) return '0;
        mag = sum[31] ? (33'd0 - {1'b1, sum}) : {1'b0, sum};
        quo = mag / {1'b0, cnt};
        return sum[31] ? (32'd0 - quo[31:0]) : quo[31:0];
      end
      AGG_COUNT: return cnt;
      default:   return '0;
    endcase
  endfunction

  function automatic logic having_ok(input logic [2:0] op, input logic signed [31:0] v,
                                     input logic signed [31:0] t);
    case (op)
      CMP_LT:  return v < t;
      CMP_GT:  return v > t;
      CMP_LE:  return v <= t;
      CMP_GE:  return v >= t;
      CMP_EQ:  return v == t;
      CMP_NE:  return v != t;
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count_o = fail_count_o + 1;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic clear_group();
    hav_min = 32'sh7fff_ffff;
    hav_max = 32'sh8000_0000;
    hav_sum = '0;
    res_min = 32'sh7fff_ffff;
    res_max = 32'sh8000_0000;
    res_sum = '0;
    tally   = '0;
  endtask

  task automatic close_group();
    logic signed [31:0] hval;
    logic signed [31:0] rval;
    group_row_t         row;
    hval = aggregate_of(hav_fn, hav_min, hav_max, hav_sum, tally);
    rval = aggregate_of(res_fn, res_min, res_max, res_sum, tally);
    if (having_ok(cmp_sel, hval, thr)) begin
      row.key  = grp_key;
      row.agg  = rval;
      row.last = 1'b0;
      step_rows.insert(step_rows.size(), row);
    end
    clear_group();
  endtask

  task automatic fold_row(input logic signed [31:0] key, input logic signed [31:0] hv,
                          input logic signed [31:0] rv, input logic last);
    step_rows.delete();
    if (grp_open && key != grp_key) begin
      close_group();
      grp_open = 1'b0;
    end
    if (!grp_open) begin
      clear_group();
      grp_key  = key;
      grp_open = 1'b1;
    end
    if (hv < hav_min) hav_min = hv;
    if (hv > hav_max) hav_max = hv;
    hav_sum = hav_sum + hv;
    if (rv < res_min) res_min = rv;
    if (rv > res_max) res_max = rv;
    res_sum = res_sum + rv;
    tally   = tally + 32'd1;
    if (last) begin
      close_group();
      grp_open = 1'b0;
    end
    if (step_rows.size() > 0) step_rows[step_rows.size() - 1].last = 1'b1;
    foreach (step_rows[i]) passed_q.insert(passed_q.size(), step_rows[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    group_row_t want;
    if (!rst_ni) begin
      hav_fn       = '0;
      res_fn       = '0;
      cmp_sel      = '0;
      thr          = '0;
      grp_open     = 1'b0;
      grp_key      = '0;
      clear_group();
      passed_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (passed_q.size() == 0) begin
          report_mismatch($sformatf("output key %0d with no group expected",
                                    $signed(m_tdata_i[31:0])));
        end else begin
          want = passed_q.pop_front();
          if (m_tdata_i[31:0] !== want.key)
            report_mismatch($sformatf("out_key %0d, expected %0d",
                                      $signed(m_tdata_i[31:0]), $signed(want.key)));
          if (m_tdata_i[63:32] !== want.agg)
            report_mismatch($sformatf("aggregate %0d for key %0d, expected %0d",
                                      $signed(m_tdata_i[63:32]), $signed(want.key),
                                      $signed(want.agg)));
          if (m_tlast_i !== want.last)
            report_mismatch($sformatf("last_of_run %b for key %0d, expected %b",
                                      m_tlast_i, $signed(want.key), want.last));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HAVING_FUNC: hav_fn  = cfg_data_i[2:0];
          CFG_RESULT_FUNC: res_fn  = cfg_data_i[2:0];
          CFG_COMPARE_OP:  cmp_sel = cfg_data_i[2:0];
          CFG_THRESHOLD:   thr     = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        fold_row(s_tdata_i[31:0], s_tdata_i[63:32], s_tdata_i[95:64], s_tlast_i);
      pending_o = passed_q.size();
    end
  end

endmodule

### tb/sv/sorted_group_aggregate_having_test.sv
`timescale 1ns / 1ps
// Top of the sorted_group_aggregate_having testbench: clock, reset, config writes and
// row stimulus with random idling; verdict from sorted_group_aggregate_having_check.
// Depends on sga_pkg, the block and the checker.
module sorted_group_aggregate_having_test;
  import sga_pkg::*;

  localparam logic [31:0] IntMin     = 32'h8000_0000;
  localparam logic [31:0] IntMax     = 32'h7fff_ffff;
  localparam int          TailCycles = 100;
  localparam int          CycleLimit = 1_000_000;
  localparam int          RowTarget  = 900;
  localparam int          CalmAfter  = 780;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [95:0]             s_tdata = '0;  // group_key, having_value, result_value
  logic                    s_tlast = 1'b0;  // last_row
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [63:0]             m_tdata;  // out_key, aggregate
  logic                    m_tlast;  // last_of_run

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   rows_sent = 0;
  int   stall_left = 0;
  logic idle_on = 1'b1;

  sorted_group_aggregate_having dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  sorted_group_aggregate_having_check checker_u (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stall the output side in short bursts until idling is switched off
  always @(posedge clk) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else if (!idle_on) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_row(input logic [31:0] key, input logic [31:0] hv,
                          input logic [31:0] rv, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rv, hv, key};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rows_sent = rows_sent + 1;
    if (rows_sent >= CalmAfter) idle_on <= 1'b0;
  endtask

  // hold until every predicted result has left and the block is back to taking rows
  task automatic wait_for_groups();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0 || !s_tready);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] hf, input logic [2:0] rf,
                            input logic [2:0] op, input logic [31:0] thr);
    logic [31:0] vals [4];
    vals[CFG_HAVING_FUNC] = {29'd0, hf};
    vals[CFG_RESULT_FUNC] = {29'd0, rf};
    vals[CFG_COMPARE_OP]  = {29'd0, op};
    vals[CFG_THRESHOLD]   = thr;
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= i[CfgIdxWidth-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] make_value(input int mode);
    case (mode)
      0: return 32'($urandom_range(0, 16)) - 32'd8;
      1: return $urandom();
      2: begin
        case ($urandom_range(0, 5))
          0:       return IntMin;
          1:       return IntMax;
          2:       return 32'd0;
          3:       return 32'hffff_ffff;
          4:       return 32'($urandom_range(0, 16)) - 32'd8;
          default: return $urandom();
        endcase
      end
      default: return 32'($urandom_range(0, 200)) - 32'd100;
    endcase
  endfunction

  task automatic run_random_phase(input int rows);
    logic [31:0] key;
    logic [31:0] hv;
    logic [31:0] rv;
    logic        last;
    int          left_in_group;
    int          mode;
    mode          = $urandom_range(0, 3);
    key           = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 40)) - 32'd20;
    left_in_group = $urandom_range(1, 5);
    for (int i = 0; i < rows; i++) begin
      if (left_in_group == 0) begin
        case ($urandom_range(0, 9))
          0:       key = $urandom();
          1:       key = key - 32'($urandom_range(1, 4));
          default: key = key + 32'($urandom_range(1, 3));
        endcase
        left_in_group = $urandom_range(1, 6);
      end
      left_in_group = left_in_group - 1;
      hv   = make_value(mode);
      rv   = make_value(mode);
      last = (i == rows - 1) || ($urandom_range(0, 39) == 0);
      send_row(key, hv, rv, last);
      if ($urandom_range(0, 199) == 0) wait_for_groups();
    end
  endtask

  initial begin
    logic [2:0]  hf;
    logic [2:0]  rf;
    logic [2:0]  op;
    logic [31:0] thr;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count / sum, open groups closed by key change, last row and unsorted keys
    set_config(AGG_COUNT, AGG_SUM, CMP_GE, 32'd1);
    send_row(IntMin, IntMax, IntMin, 1'b0);
    send_row(IntMin, IntMin, IntMin, 1'b0);
    send_row(32'hffff_ffff, 32'd0, 32'hffff_ffff, 1'b0);
    send_row(32'd0, 32'd5, 32'd7, 1'b1);
    send_row(32'd3, 32'd1, 32'd2, 1'b1);
    send_row(32'd3, 32'hffff_ffff, 32'd4, 1'b0);
    send_row(IntMax, 32'd2, 32'd3, 1'b0);
    send_row(32'd5, 32'd0, 32'd0, 1'b1);
    wait_for_groups();

    // averages: negative truncation, INT_MIN, wrapped sums
    set_config(AGG_AVG, AGG_AVG, CMP_NE, IntMin);
    send_row(32'd10, -32'd3, -32'd4, 1'b0);
    send_row(32'd10, -32'd4, -32'd3, 1'b0);
    send_row(32'd11, IntMin, IntMin, 1'b0);
    send_row(32'd12, IntMin, IntMax, 1'b0);
    send_row(32'd12, IntMin, IntMax, 1'b0);
    send_row(32'd13, IntMax, 32'd9, 1'b1);
    wait_for_groups();

    set_config(AGG_MIN, AGG_MAX, CMP_EQ, -32'd5);
    send_row(-32'd7, -32'd5, 32'd1, 1'b0);
    send_row(-32'd7, 32'd3, -32'd2, 1'b0);
    send_row(-32'd6, -32'd4, 32'd0, 1'b1);
    wait_for_groups();

    set_config(AGG_MAX, AGG_MIN, CMP_GT, -32'd3);
    send_row(32'd1, -32'd1, 32'd6, 1'b0);
    send_row(32'd1, -32'd2, 32'd5, 1'b1);
    send_row(32'd2, -32'd9, 32'd1, 1'b1);
    wait_for_groups();

    set_config(AGG_SUM, AGG_COUNT, CMP_LE, IntMax);
    send_row(32'd4, IntMax, 32'd1, 1'b0);
    send_row(32'd4, 32'd1, 32'd1, 1'b1);
    wait_for_groups();

    set_config(AGG_COUNT, AGG_MIN, CMP_LT, 32'd2);
    send_row(32'd9, 32'd0, -32'd8, 1'b0);
    send_row(32'd9, 32'd0, 32'd4, 1'b0);
    send_row(32'd10, 32'd0, 32'd3, 1'b1);
    wait_for_groups();

    while (rows_sent < RowTarget) begin
      hf = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      rf = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 5))
        0:       thr = IntMin;
        1:       thr = IntMax;
        2:       thr = $urandom();
        default: thr = 32'($urandom_range(0, 12)) - 32'd4;
      endcase
      set_config(hf, rf, op, thr);
      run_random_phase($urandom_range(20, 80));
      wait_for_groups();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
